>>> design/ppi_keyboard_matrix_port_assert.svh
// Assertion macros shared by the keyboard matrix port RTL.
`ifndef PPI_KEYBOARD_MATRIX_PORT_ASSERT_SVH
`define PPI_KEYBOARD_MATRIX_PORT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define KMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/kmp_pkg.sv
package kmp_pkg;

    // Item kinds
    localparam logic [2:0] MODE_BUS_WRITE   = 3'd0;
    localparam logic [2:0] MODE_BUS_READ    = 3'd1;
    localparam logic [2:0] MODE_KEY_PRESS   = 3'd2;
    localparam logic [2:0] MODE_KEY_RELEASE = 3'd3;
    localparam logic [2:0] MODE_RELEASE_ALL = 3'd4;

    // Port addresses
    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    localparam int unsigned ROWS      = 8;
    localparam int unsigned ROW_W     = $clog2(ROWS);

    localparam logic [7:0] MOD_SS_BIT    = 8'h20;
    localparam logic [7:0] PORTC_KEEP    = 8'hEF;
    localparam logic [7:0] TAPE_BIT      = 8'h10;
    localparam logic [7:0] CTRL_MODE_BIT = 8'h80;
    localparam logic [2:0] RUS_PIN       = 3'd3;

    typedef struct packed {
        logic load;
    } cmd_t;

endpackage

>>> design/kmp_intf.sv
interface kmp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [1:0]  port;
    logic [7:0]  write_data;
    logic [15:0] key_code;
    logic        tape_level;

    modport source (
        output valid, mode, port, write_data, key_code, tape_level,
        input  ready
    );
    modport sink (
        input  valid, mode, port, write_data, key_code, tape_level,
        output ready
    );
endinterface

interface kmp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tape_toggle;
    logic       rus_flag;
    logic       ss_pressed;

    modport source (
        output valid, read_data, tape_toggle, rus_flag, ss_pressed,
        input  ready
    );
    modport sink (
        input  valid, read_data, tape_toggle, rus_flag, ss_pressed,
        output ready
    );
endinterface

>>> design/kmp_ctrl.sv
module kmp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output kmp_pkg::cmd_t  cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new item whenever the result register is free or being emptied.
    assign req_ready = (state_reg == ST_EMPTY) || rsp_ready;
    assign rsp_valid = (state_reg == ST_FULL);
    assign cmd.load  = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        if (cmd.load)
        begin
            state_next = ST_FULL;
        end
        else if (rsp_ready)
        begin
            state_next = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/kmp_datapath.sv
module kmp_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  kmp_pkg::cmd_t  cmd,
    input  logic [2:0]     mode,
    input  logic [1:0]     port,
    input  logic [7:0]     write_data,
    input  logic [15:0]    key_code,
    input  logic           tape_level,
    output logic [7:0]     read_data,
    output logic           tape_toggle,
    output logic           rus_flag,
    output logic           ss_pressed
);

    logic [7:0] scan_line_reg, scan_line_next;
    logic [7:0] modifier_reg, modifier_next;
    logic       rus_mode_reg, rus_mode_next;
    logic       last_tape_reg, last_tape_next;
    logic [7:0] matrix_reg [kmp_pkg::ROWS];
    logic [7:0] matrix_next [kmp_pkg::ROWS];

    logic [7:0] read_data_reg, read_data_next;
    logic       toggle_reg, toggle_next;
    logic       rus_flag_reg;
    logic       ss_reg;

    logic [7:0]                mods;
    logic [kmp_pkg::ROW_W-1:0] row;
    logic [7:0]                cols;
    logic                      is_mod;
    logic [7:0]                port_b;

    assign mods   = {key_code[15:12], 4'b0000};
    assign row    = key_code[8 +: kmp_pkg::ROW_W];
    assign cols   = key_code[7:0];
    assign is_mod = |key_code[15:12];

    // AND of the rows selected by a low scan bit
    always_comb
    begin
        port_b = 8'hFF;
        for (int i = 0; i < kmp_pkg::ROWS; i++)
        begin
            if (!scan_line_reg[i])
            begin
                port_b = port_b & matrix_reg[i];
            end
        end
    end

    always_comb
    begin
        scan_line_next = scan_line_reg;
        modifier_next  = modifier_reg;
        rus_mode_next  = rus_mode_reg;
        last_tape_next = last_tape_reg;
        matrix_next    = matrix_reg;
        read_data_next = 8'h00;
        toggle_next    = 1'b0;

        unique case (mode)
            kmp_pkg::MODE_BUS_WRITE:
            begin
                unique case (port)
                    kmp_pkg::PORT_A:
                    begin
                        scan_line_next = write_data;
                    end
                    kmp_pkg::PORT_C:
                    begin
                        toggle_next    = write_data[0] != last_tape_reg;
                        last_tape_next = write_data[0];
                    end
                    kmp_pkg::PORT_CTRL:
                    begin
                        if (((write_data & kmp_pkg::CTRL_MODE_BIT) == 8'h00)
                            && (write_data[3:1] == kmp_pkg::RUS_PIN))
                        begin
                            rus_mode_next = write_data[0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            kmp_pkg::MODE_BUS_READ:
            begin
                unique case (port)
                    kmp_pkg::PORT_A: read_data_next = scan_line_reg;
                    kmp_pkg::PORT_B: read_data_next = port_b;
                    kmp_pkg::PORT_C: read_data_next = (modifier_reg & kmp_pkg::PORTC_KEEP)
                                                      | (tape_level ? kmp_pkg::TAPE_BIT : 8'h00);
                    default:         read_data_next = 8'h00;
                endcase
            end
            kmp_pkg::MODE_KEY_PRESS:
            begin
                if (is_mod)
                begin
                    modifier_next = modifier_reg & ~mods;
                end
                else
                begin
                    matrix_next[row] = matrix_reg[row] & ~cols;
                end
            end
            kmp_pkg::MODE_KEY_RELEASE:
            begin
                if (is_mod)
                begin
                    modifier_next = modifier_reg | mods;
                end
                else
                begin
                    matrix_next[row] = matrix_reg[row] | cols;
                end
            end
            kmp_pkg::MODE_RELEASE_ALL:
            begin
                modifier_next = modifier_reg | mods;
                for (int i = 0; i < kmp_pkg::ROWS; i++)
                begin
                    matrix_next[i] = 8'hFF;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_line_reg <= 8'h00;
            modifier_reg  <= 8'hFF;
            rus_mode_reg  <= 1'b0;
            last_tape_reg <= 1'b0;
            for (int i = 0; i < kmp_pkg::ROWS; i++)
            begin
                matrix_reg[i] <= 8'hFF;
            end
        end
        else if (cmd.load)
        begin
            scan_line_reg <= scan_line_next;
            modifier_reg  <= modifier_next;
            rus_mode_reg  <= rus_mode_next;
            last_tape_reg <= last_tape_next;
            matrix_reg    <= matrix_next;
        end
    end

    // Result register: hold until the next item is loaded
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_data_reg <= read_data_next;
            toggle_reg    <= toggle_next;
            rus_flag_reg  <= rus_mode_next;
            ss_reg        <= (modifier_next & kmp_pkg::MOD_SS_BIT) == 8'h00;
        end
    end

    assign read_data   = read_data_reg;
    assign tape_toggle = toggle_reg;
    assign rus_flag    = rus_flag_reg;
    assign ss_pressed  = ss_reg;

endmodule

>>> design/ppi_keyboard_matrix_port.sv
// Keyboard matrix port of an 8255-style parallel interface. Each item on req is a bus
// write, a bus read, a key press, a key release or a release of all keys, and gives
// exactly one result on rsp, registered in the cycle after the item is accepted. The block
// takes one item per cycle: the result register is the only stage, and req.ready stays
// high while that register is empty or being taken, so a stalled rsp stalls req. Matrix
// and modifier bits are active low and reset to all ones; port B reads are an AND over
// the eight matrix rows whose scan bit is low.
`include "ppi_keyboard_matrix_port_assert.svh"

module ppi_keyboard_matrix_port (
    input  logic             clk,
    input  logic             rst_n,
    kmp_req_if.sink          req,
    kmp_rsp_if.source        rsp
);

    kmp_pkg::cmd_t cmd;

    kmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    kmp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (req.mode),
        .port        (req.port),
        .write_data  (req.write_data),
        .key_code    (req.key_code),
        .tape_level  (req.tape_level),
        .read_data   (rsp.read_data),
        .tape_toggle (rsp.tape_toggle),
        .rus_flag    (rsp.rus_flag),
        .ss_pressed  (rsp.ss_pressed)
    );

    `KMP_ASSERT_NEXT(a_item_gives_result, clk, rst_n, req.valid && req.ready, rsp.valid, "accepted item produced no result")
    `KMP_ASSERT_IMPL(a_no_overwrite, clk, rst_n, rsp.valid && !rsp.ready, !req.ready, "pending result would be overwritten")
    `KMP_ASSERT_IMPL(a_toggle_no_read, clk, rst_n, rsp.valid && rsp.tape_toggle, rsp.read_data == 8'h00, "tape toggle together with read data")

endmodule

>>> sim/ppi_keyboard_matrix_port_tb.sv
module ppi_keyboard_matrix_port_tb;

    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 300;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_AT     = 700;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  port;
        logic [7:0]  wdata;
        logic [15:0] code;
        logic        tape;
        logic        drain_first;
    } kbd_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tape_toggle;
        logic       rus_flag;
        logic       ss_pressed;
    } kbd_result_t;

    logic clk = 1'b0;
    logic rst_n;

    kmp_req_if req_ch ();
    kmp_rsp_if rsp_ch ();

    ppi_keyboard_matrix_port i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // Predicted port state
    logic [7:0] m_scan;
    logic [7:0] m_mods;
    logic       m_rus;
    logic [7:0] m_matrix [kmp_pkg::ROWS];
    logic       m_tape_bit;

    kbd_item_t   pending_items [$];
    kbd_result_t expected_responses [$];
    kbd_item_t   cur_item;
    kbd_result_t got_rsp;
    kbd_result_t want_rsp;
    int          total_items;
    int          n_errors;
    int          n_results;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          hold_done;

    function automatic kbd_result_t port_response(kbd_item_t it);
        kbd_result_t r;
        logic [7:0]  mods;
        logic [7:0]  cols;
        logic [7:0]  acc;
        logic [2:0]  row;
        logic        is_mod;
        mods   = {it.code[15:12], 4'h0};
        row    = it.code[10:8];
        cols   = it.code[7:0];
        is_mod = |it.code[15:12];
        r      = '0;
        case (it.mode)
            kmp_pkg::MODE_BUS_WRITE:
                case (it.port)
                    kmp_pkg::PORT_A: m_scan = it.wdata;
                    kmp_pkg::PORT_C:
                    begin
                        r.tape_toggle = (it.wdata[0] != m_tape_bit);
                        m_tape_bit    = it.wdata[0];
                    end
                    kmp_pkg::PORT_CTRL:
                        if ((it.wdata & kmp_pkg::CTRL_MODE_BIT) == 8'h00
                            && it.wdata[3:1] == kmp_pkg::RUS_PIN)
                            m_rus = it.wdata[0];
                    default: ;
                endcase
            kmp_pkg::MODE_BUS_READ:
                case (it.port)
                    kmp_pkg::PORT_A: r.read_data = m_scan;
                    kmp_pkg::PORT_B:
                    begin
                        acc = 8'hFF;
                        for (int i = 0; i < kmp_pkg::ROWS; i++)
                            if (!m_scan[i])
                                acc &= m_matrix[i];
                        r.read_data = acc;
                    end
                    kmp_pkg::PORT_C: r.read_data = (m_mods & kmp_pkg::PORTC_KEEP)
                                                   | (it.tape ? kmp_pkg::TAPE_BIT : 8'h00);
                    default: r.read_data = 8'h00;
                endcase
            kmp_pkg::MODE_KEY_PRESS:
                if (is_mod)
                    m_mods &= ~mods;
                else
                    m_matrix[row] &= ~cols;
            kmp_pkg::MODE_KEY_RELEASE:
                if (is_mod)
                    m_mods |= mods;
                else
                    m_matrix[row] |= cols;
            kmp_pkg::MODE_RELEASE_ALL:
            begin
                m_mods |= mods;
                for (int i = 0; i < kmp_pkg::ROWS; i++)
                    m_matrix[i] = 8'hFF;
            end
            default: ;
        endcase
        r.rus_flag   = m_rus;
        r.ss_pressed = ((m_mods & kmp_pkg::MOD_SS_BIT) == 8'h00);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d, %0s: got %0h, expected %0h", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic add_item(logic [2:0] mode, logic [1:0] port, logic [7:0] wdata,
                            logic [15:0] code, logic tape);
        kbd_item_t it;
        it.mode        = mode;
        it.port        = port;
        it.wdata       = wdata;
        it.code        = code;
        it.tape        = tape;
        it.drain_first = (pending_items.size() == DIRECTED_ITEMS ||
                          pending_items.size() == DRAIN_AT);
        pending_items.push_back(it);
    endtask

    // Driver: offer items from the pending queue, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_responses.push_back(port_response(cur_item));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (pending_items[0].drain_first && expected_responses.size() != 0)
                    req_ch.valid <= 1'b0;
                else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    gap_left = int'($urandom_range(1, 14)) - 1;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    cur_item = pending_items.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.mode       <= cur_item.mode;
                    req_ch.port       <= cur_item.port;
                    req_ch.write_data <= cur_item.wdata;
                    req_ch.key_code   <= cur_item.code;
                    req_ch.tape_level <= cur_item.tape;
                end
            end
        end
    end

    // Monitor: check results in order and throttle the response side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                got_rsp = {rsp_ch.read_data, rsp_ch.tape_toggle, rsp_ch.rus_flag,
                           rsp_ch.ss_pressed};
                if (expected_responses.size() == 0)
                    report_mismatch("result with nothing expected", got_rsp, 0);
                else
                begin
                    want_rsp = expected_responses.pop_front();
                    if (got_rsp.read_data !== want_rsp.read_data)
                        report_mismatch("read_data", got_rsp.read_data, want_rsp.read_data);
                    if (got_rsp.tape_toggle !== want_rsp.tape_toggle)
                        report_mismatch("tape_toggle", got_rsp.tape_toggle,
                                        want_rsp.tape_toggle);
                    if (got_rsp.rus_flag !== want_rsp.rus_flag)
                        report_mismatch("rus_flag", got_rsp.rus_flag, want_rsp.rus_flag);
                    if (got_rsp.ss_pressed !== want_rsp.ss_pressed)
                        report_mismatch("ss_pressed", got_rsp.ss_pressed, want_rsp.ss_pressed);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                // hold off long enough to back the block up into the request side
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (n_results < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                stall_left = int'($urandom_range(1, 14)) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #1600000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        kbd_item_t it;
        int        sel;
        int        r;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = kmp_pkg::MODE_BUS_READ;
        req_ch.port       = kmp_pkg::PORT_A;
        req_ch.write_data = 8'h00;
        req_ch.key_code   = 16'h0000;
        req_ch.tape_level = 1'b0;
        rsp_ch.ready      = 1'b0;
        n_errors          = 0;
        n_results         = 0;

        m_scan     = 8'h00;
        m_mods     = 8'hFF;
        m_rus      = 1'b0;
        m_tape_bit = 1'b0;
        for (int i = 0; i < kmp_pkg::ROWS; i++)
            m_matrix[i] = 8'hFF;

        // directed: reset values, ignored writes, pin set/reset, tape edges, modifiers
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_A,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_B,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_C,    8'h00, 16'h0000, 1'b1);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_B,    8'h5A, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_KEY_PRESS,   kmp_pkg::PORT_A,    8'h00, 16'h0001, 1'b0);
        add_item(kmp_pkg::MODE_KEY_PRESS,   kmp_pkg::PORT_A,    8'h00, 16'h0F80, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_B,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_A,    8'hFE, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_B,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_A,    8'hFF, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_B,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_CTRL, 8'h07, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_CTRL, 8'h86, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_CTRL, 8'h04, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_CTRL, 8'h06, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_C,    8'h01, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_C,    8'h01, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_WRITE,   kmp_pkg::PORT_C,    8'hFE, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_KEY_PRESS,   kmp_pkg::PORT_A,    8'h00, 16'h2000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_C,    8'h00, 16'h0000, 1'b1);
        add_item(kmp_pkg::MODE_KEY_PRESS,   kmp_pkg::PORT_A,    8'h00, 16'hF0FF, 1'b0);
        add_item(kmp_pkg::MODE_RELEASE_ALL, kmp_pkg::PORT_A,    8'h00, 16'h2000, 1'b0);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_C,    8'h00, 16'h0000, 1'b0);
        add_item(kmp_pkg::MODE_KEY_RELEASE, kmp_pkg::PORT_A,    8'h00, 16'hF000, 1'b0);
        add_item(MODE_UNUSED_LAST,          kmp_pkg::PORT_CTRL, 8'hFF, 16'hFFFF, 1'b1);
        add_item(kmp_pkg::MODE_BUS_READ,    kmp_pkg::PORT_CTRL, 8'h00, 16'h0000, 1'b1);

        // random: mostly scan/press/read/release sequences, the rest loose items
        while (pending_items.size() < RANDOM_ITEMS + DIRECTED_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r = int'($urandom_range(0, kmp_pkg::ROWS - 1));
                add_item(kmp_pkg::MODE_BUS_WRITE, kmp_pkg::PORT_A, ~(8'h01 << r), 16'h0000,
                         1'($urandom_range(0, 1)));
                it.code[15:12] = 4'h0;
                it.code[11]    = 1'($urandom_range(0, 1));
                it.code[10:8]  = 3'(r);
                it.code[7:0]   = 8'($urandom_range(1, 255));
                add_item(kmp_pkg::MODE_KEY_PRESS, 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), it.code, 1'($urandom_range(0, 1)));
                add_item(kmp_pkg::MODE_BUS_READ, kmp_pkg::PORT_B, 8'($urandom_range(0, 255)),
                         16'h0000, 1'b0);
                if ($urandom_range(0, 1) != 0)
                    add_item(kmp_pkg::MODE_KEY_RELEASE, kmp_pkg::PORT_A, 8'h00, it.code, 1'b0);
                add_item(kmp_pkg::MODE_BUS_READ, kmp_pkg::PORT_B, 8'h00,
                         16'($urandom_range(0, 65535)), 1'b1);
            end
            else
            begin
                sel = int'($urandom_range(0, 99));
                if (sel < 25)
                    it.mode = kmp_pkg::MODE_BUS_WRITE;
                else if (sel < 55)
                    it.mode = kmp_pkg::MODE_BUS_READ;
                else if (sel < 75)
                    it.mode = kmp_pkg::MODE_KEY_PRESS;
                else if (sel < 87)
                    it.mode = kmp_pkg::MODE_KEY_RELEASE;
                else if (sel < 94)
                    it.mode = kmp_pkg::MODE_RELEASE_ALL;
                else
                    it.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
                it.port  = 2'($urandom_range(0, 3));
                it.wdata = 8'($urandom_range(0, 255));
                if (it.mode == kmp_pkg::MODE_BUS_WRITE && it.port == kmp_pkg::PORT_CTRL
                    && $urandom_range(0, 1) != 0)
                begin
                    it.wdata[7]   = 1'b0;
                    it.wdata[3:1] = kmp_pkg::RUS_PIN;
                end
                if (it.mode == kmp_pkg::MODE_BUS_WRITE && it.port == kmp_pkg::PORT_A
                    && $urandom_range(0, 1) != 0)
                    it.wdata = ~(8'h01 << $urandom_range(0, 7));
                if ($urandom_range(0, 2) == 0)
                begin
                    it.code[15:12] = 4'($urandom_range(1, 15));
                    it.code[11:0]  = 12'($urandom_range(0, 4095));
                end
                else
                begin
                    it.code[15:12] = 4'h0;
                    it.code[11:8]  = 4'($urandom_range(0, 15));
                    it.code[7:0]   = ($urandom_range(0, 1) != 0)
                                     ? (8'h01 << $urandom_range(0, 7))
                                     : 8'($urandom_range(0, 255));
                end
                it.tape        = 1'($urandom_range(0, 1));
                it.drain_first = (pending_items.size() == DIRECTED_ITEMS ||
                                  pending_items.size() == DRAIN_AT);
                pending_items.push_back(it);
            end
        end
        total_items = pending_items.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || req_ch.valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/kmp_pkg.sv
design/kmp_intf.sv
design/kmp_ctrl.sv
design/kmp_datapath.sv
design/ppi_keyboard_matrix_port.sv
sim/ppi_keyboard_matrix_port_tb.sv
